// ===== rtl/fas_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fas_pkg;

	// Operation codes carried on cmd
	typedef enum logic {
		CMD_ADD = 1'b0,
		CMD_SUB = 1'b1
	} cmd_t;

	// Fixed widths of the result fields
	localparam int NUM_OUT_W = 33;
	localparam int DEN_OUT_W = 31;

	// Status of the reduction unit seen by the top level
	typedef struct packed {
		logic busy;
		logic done;
	} red_status_t;

endpackage

`default_nettype wire

// ===== rtl/fas_reduce.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Reduces num/den by their gcd: binary gcd, then two restoring divisions,
// all on one shared subtractor. Inputs must both be nonzero.
module fas_reduce #(
	parameter int PROD_WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [PROD_WIDTH-1:0]   num_in,
	input  wire logic [PROD_WIDTH-1:0]   den_in,
	output fas_pkg::red_status_t         status,
	output logic      [PROD_WIDTH-1:0]   num_out,
	output logic      [PROD_WIDTH-1:0]   den_out
);

	localparam int PW = PROD_WIDTH;
	localparam int CW = $clog2(PW);

	typedef enum logic [4:0] {
		R_IDLE   = 5'b00001,
		R_COMMON = 5'b00010,
		R_GCD    = 5'b00100,
		R_DIV_N  = 5'b01000,
		R_DIV_D  = 5'b10000
	} red_state_t;

	red_state_t      state_q;
	logic [PW-1:0]   x_q;      // gcd operand, later the divisor
	logic [PW-1:0]   y_q;      // gcd operand, later the partial remainder
	logic [PW-1:0]   n_q;      // numerator with common twos removed, then quotient
	logic [PW-1:0]   d_q;      // denominator with common twos removed, then quotient
	logic [CW-1:0]   cnt_q;
	logic            done_q;

	logic [PW:0]     sub_a;
	logic [PW:0]     sub_b;
	logic [PW:0]     diff;
	logic            dvd_msb;
	logic            q_bit;
	logic [PW-1:0]   rem_next;

	// Shared subtractor: gcd step or trial subtract of the divider
	always_comb begin
		dvd_msb = (state_q == R_DIV_N) ? n_q[PW-1] : d_q[PW-1];
		if (state_q == R_GCD) begin
			sub_a = {1'b0, x_q};
		end else begin
			sub_a = {y_q, dvd_msb};
		end
		sub_b = (state_q == R_GCD) ? {1'b0, y_q} : {1'b0, x_q};
		diff = sub_a - sub_b;
		q_bit = ~diff[PW];
		rem_next = q_bit ? diff[PW-1:0] : {y_q[PW-2:0], dvd_msb};
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: begin
					if (start) begin
						state_q <= R_COMMON;
					end
				end
				R_COMMON: begin
					if (x_q[0] || y_q[0]) begin
						state_q <= R_GCD;
					end
				end
				R_GCD: begin
					if (x_q[0] && y_q[0] && (diff == '0)) begin
						state_q <= R_DIV_N;
						cnt_q   <= '0;
					end
				end
				R_DIV_N: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(PW - 1)) begin
						state_q <= R_DIV_D;
						cnt_q   <= '0;
					end
				end
				R_DIV_D: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(PW - 1)) begin
						state_q <= R_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= R_IDLE;
				end
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			R_IDLE: begin
				if (start) begin
					x_q <= num_in;
					y_q <= den_in;
				end
			end
			R_COMMON: begin
				// Strip shared factors of two; they cancel in the quotients
				if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
				end else begin
					n_q <= x_q;
					d_q <= y_q;
				end
			end
			R_GCD: begin
				if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (diff == '0) begin
					y_q <= '0;
				end else if (diff[PW]) begin
					x_q <= y_q;
					y_q <= x_q;
				end else begin
					x_q <= diff[PW-1:0];
				end
			end
			R_DIV_N: begin
				n_q <= {n_q[PW-2:0], q_bit};
				y_q <= (cnt_q == CW'(PW - 1)) ? '0 : rem_next;
			end
			R_DIV_D: begin
				d_q <= {d_q[PW-2:0], q_bit};
				y_q <= rem_next;
			end
			default: begin
			end
		endcase
	end

	assign status.busy = (state_q != R_IDLE);
	assign status.done = done_q;
	assign num_out     = n_q;
	assign den_out     = d_q;

endmodule

`default_nettype wire

// ===== rtl/fraction_add_sub_reduce_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Flow: the cross products are formed in states T_MUL_A to T_MUL_D, then common-twos stripping, a binary
// gcd loop and two restoring divisions of 2*OPERAND_WIDTH quotient bits each run on one shared
// subtractor in fas_reduce; the gcd loop and the divider on that subtractor set the total time.
// One transaction at a time: a new one is accepted only in T_IDLE; a zero denominator skips to T_DONE.
// Reset: arst_n clears the sequencers and output valid; data registers are not reset.
module fraction_add_sub_reduce_core #(
	parameter int OPERAND_WIDTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              cmd,
	input  wire logic signed [OPERAND_WIDTH-1:0]   a_num,
	input  wire logic signed [OPERAND_WIDTH-1:0]   a_den,
	input  wire logic signed [OPERAND_WIDTH-1:0]   b_num,
	input  wire logic signed [OPERAND_WIDTH-1:0]   b_den,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [fas_pkg::NUM_OUT_W-1:0]   result_num,
	output logic        [fas_pkg::DEN_OUT_W-1:0]   result_den,
	output logic                                   div_zero
);

	localparam int W  = OPERAND_WIDTH;
	localparam int PW = 2 * OPERAND_WIDTH;
	localparam int NW = (PW + 1 > fas_pkg::NUM_OUT_W) ? PW + 1 : fas_pkg::NUM_OUT_W;
	localparam int DW = (PW > fas_pkg::DEN_OUT_W) ? PW : fas_pkg::DEN_OUT_W;

	typedef enum logic [6:0] {
		T_IDLE   = 7'b0000001,
		T_MUL_A  = 7'b0000010,
		T_MUL_B  = 7'b0000100,
		T_MUL_C  = 7'b0001000,
		T_MUL_D  = 7'b0010000,
		T_REDUCE = 7'b0100000,
		T_DONE   = 7'b1000000
	} top_state_t;

	top_state_t            state_q;
	fas_pkg::cmd_t         cmd_q;
	logic [W-1:0]          an_mag_q, ad_mag_q, bn_mag_q, bd_mag_q;
	logic                  an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic                  dz_q;
	logic                  zero_q;
	logic                  neg_q;
	logic [PW-1:0]         p_q;
	logic signed [PW:0]    s_q;
	logic                  out_valid_q;

	logic [W-1:0]          an_mag, ad_mag, bn_mag, bd_mag;
	logic                  accept;
	logic                  den_zero;
	logic [W-1:0]          mul_a, mul_b;
	logic [PW:0]           p_ext, p_term;
	logic                  term_neg;
	logic [PW-1:0]         num_mag;
	logic                  red_start;
	logic                  out_load;
	fas_pkg::red_status_t  red_status;
	logic [PW-1:0]         red_num, red_den;
	logic [NW-1:0]         num_ext, num_sgn;
	logic [DW-1:0]         den_ext;

	// Operand magnitudes
	always_comb begin
		an_mag = a_num[W-1] ? (~a_num + 1'b1) : a_num;
		ad_mag = a_den[W-1] ? (~a_den + 1'b1) : a_den;
		bn_mag = b_num[W-1] ? (~b_num + 1'b1) : b_num;
		bd_mag = b_den[W-1] ? (~b_den + 1'b1) : b_den;
	end

	assign in_ready = (state_q == T_IDLE);
	assign accept   = in_valid && in_ready;
	assign den_zero = (a_den == '0) || (b_den == '0);

	// Shared multiplier operand select
	always_comb begin
		unique case (state_q)
			T_MUL_A: begin
				mul_a = an_mag_q;
				mul_b = bd_mag_q;
			end
			T_MUL_B: begin
				mul_a = ad_mag_q;
				mul_b = bn_mag_q;
			end
			default: begin
				mul_a = ad_mag_q;
				mul_b = bd_mag_q;
			end
		endcase
	end

	// Signed term of the product held in p_q
	always_comb begin
		p_ext = {1'b0, p_q};
		if (state_q == T_MUL_B) begin
			term_neg = an_neg_q ^ bd_neg_q;
		end else begin
			term_neg = ad_neg_q ^ bn_neg_q ^ (cmd_q == fas_pkg::CMD_SUB);
		end
		p_term = term_neg ? (~p_ext + 1'b1) : p_ext;
		num_mag = s_q[PW] ? PW'(~s_q + 1'b1) : PW'(s_q);
	end

	assign red_start = (state_q == T_MUL_D) && (s_q != '0);
	assign out_load  = (state_q == T_DONE) && (!out_valid_q || out_ready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						state_q <= den_zero ? T_DONE : T_MUL_A;
					end
				end
				T_MUL_A: state_q <= T_MUL_B;
				T_MUL_B: state_q <= T_MUL_C;
				T_MUL_C: state_q <= T_MUL_D;
				T_MUL_D: state_q <= red_start ? T_REDUCE : T_DONE;
				T_REDUCE: begin
					if (red_status.done) begin
						state_q <= T_DONE;
					end
				end
				T_DONE: begin
					if (out_load) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Operand capture and cross products
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= fas_pkg::cmd_t'(cmd);
			an_mag_q <= an_mag;
			ad_mag_q <= ad_mag;
			bn_mag_q <= bn_mag;
			bd_mag_q <= bd_mag;
			an_neg_q <= a_num[W-1];
			ad_neg_q <= a_den[W-1];
			bn_neg_q <= b_num[W-1];
			bd_neg_q <= b_den[W-1];
			dz_q     <= den_zero;
			zero_q   <= 1'b0;
		end
		p_q <= mul_a * mul_b;
		if (state_q == T_MUL_B) begin
			s_q <= p_term;
		end else if (state_q == T_MUL_C) begin
			s_q <= s_q + p_term;
		end
		if (state_q == T_MUL_D) begin
			zero_q <= (s_q == '0);
			neg_q  <= s_q[PW] ^ ad_neg_q ^ bd_neg_q;
		end
	end

	fas_reduce #(
		.PROD_WIDTH(PW)
	) u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (red_start),
		.num_in  (num_mag),
		.den_in  (p_q),
		.status  (red_status),
		.num_out (red_num),
		.den_out (red_den)
	);

	// Result formatting: sign onto the numerator
	always_comb begin
		num_ext = NW'(red_num);
		num_sgn = neg_q ? (~num_ext + 1'b1) : num_ext;
		den_ext = DW'(red_den);
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			div_zero <= dz_q;
			if (dz_q || zero_q) begin
				result_num <= '0;
				result_den <= fas_pkg::DEN_OUT_W'(1);
			end else begin
				result_num <= num_sgn[fas_pkg::NUM_OUT_W-1:0];
				result_den <= den_ext[fas_pkg::DEN_OUT_W-1:0];
			end
		end
	end

	assign out_valid = out_valid_q;

	// Checks
	a_divzero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && div_zero) |-> (result_num == '0 && result_den == fas_pkg::DEN_OUT_W'(1)))
		else $error("div_zero result is not 0/1");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		red_start |-> !red_status.busy)
		else $error("reduce unit started while busy");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !red_status.busy)
		else $error("input ready while reduction in progress");

	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		red_status.done |-> (state_q == T_REDUCE))
		else $error("reduce done outside wait state");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int OPW        = 16;
	localparam int NUM_W      = fas_pkg::NUM_OUT_W;
	localparam int DEN_W      = fas_pkg::DEN_OUT_W;
	localparam int RAND_ITEMS = 1230;
	localparam int DIR_N      = 20;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYC  = 300;
	localparam int HOLD_CYC   = 3000;
	localparam int HOLD_AT    = 30000;
	localparam int PAUSE_AT   = 700;

	localparam logic signed [OPW-1:0] SMIN = 16'sh8000;
	localparam logic signed [OPW-1:0] SMAX = 16'sh7FFF;

	typedef logic signed [OPW-1:0] opnd_t;

	// one reduced fraction as the block reports it
	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic        [DEN_W-1:0] den;
		logic                    dz;
	} frac_t;

	// one directed stimulus row; typed=1 means e holds the known answer
	typedef struct packed {
		fas_pkg::cmd_t c;
		opnd_t         an;
		opnd_t         ad;
		opnd_t         bn;
		opnd_t         bd;
		logic          typed;
		frac_t         e;
	} dir_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic                    cmd;
	opnd_t                   a_num;
	opnd_t                   a_den;
	opnd_t                   b_num;
	opnd_t                   b_den;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [NUM_W-1:0] result_num;
	logic        [DEN_W-1:0] result_den;
	logic                    div_zero;

	frac_t    pend_sum;
	frac_t    sum_q[$];
	frac_t    got_sum;
	int       errors;
	int       idle_cnt;
	dir_row_t dir_rows [DIR_N];

	fraction_add_sub_reduce_core #(
		.OPERAND_WIDTH(OPW)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.a_num     (a_num),
		.a_den     (a_den),
		.b_num     (b_num),
		.b_den     (b_den),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_num(result_num),
		.result_den(result_den),
		.div_zero  (div_zero)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// cross-multiply, reduce by the gcd, move the sign onto the numerator
	function automatic frac_t reduce_sum(fas_pkg::cmd_t c, opnd_t an, opnd_t ad, opnd_t bn,
		opnd_t bd);
		longint n, d, t, nm, dm, x, y, r;
		frac_t  f;
		f = '{num: '0, den: 1, dz: 1'b0};
		if (ad == 0 || bd == 0) begin
			f.dz = 1'b1;
			return f;
		end
		n = longint'(an) * longint'(bd);
		t = longint'(ad) * longint'(bn);
		n = (c == fas_pkg::CMD_SUB) ? n - t : n + t;
		d = longint'(ad) * longint'(bd);
		if (n == 0)
			return f;
		nm = (n < 0) ? -n : n;
		dm = (d < 0) ? -d : d;
		x = nm;
		y = dm;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		nm = nm / x;
		dm = dm / x;
		f.num = NUM_W'(((n < 0) != (d < 0)) ? -nm : nm);
		f.den = DEN_W'(dm);
		return f;
	endfunction

	// operand mix: corners, small values, values with shared factors, full range
	function automatic opnd_t rand_opnd();
		opnd_t corner [6];
		corner = '{SMIN, SMIN + 16'sd1, -16'sd1, 16'sd0, 16'sd1, SMAX};
		case ($urandom_range(0, 9))
			0:       return corner[$urandom_range(0, 5)];
			1, 2:    return opnd_t'($urandom_range(0, 24)) - 16'sd12;
			3:       return opnd_t'($urandom_range(1, 180) * (2 ** $urandom_range(0, 7)));
			4:       return -opnd_t'($urandom_range(1, 180) * 3 * $urandom_range(1, 40));
			default: return opnd_t'($urandom());
		endcase
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		else if (p < 85)
			return $urandom_range(1, 3);
		else if (p < 97)
			return $urandom_range(4, 20);
		else
			return $urandom_range(40, 300);
	endfunction

	// present one transaction and hold it until accepted
	task automatic send_item(fas_pkg::cmd_t c, opnd_t an, opnd_t ad, opnd_t bn, opnd_t bd,
		frac_t e);
		in_valid <= 1'b1;
		cmd      <= c;
		a_num    <= an;
		a_den    <= ad;
		b_num    <= bn;
		b_den    <= bd;
		pend_sum <= e;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic idle_sender(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// input and output monitors, sampled at the rising edge
	always @(posedge clk) begin
		if (in_valid && in_ready)
			sum_q.push_back(pend_sum);
		if (out_valid && out_ready) begin
			if (sum_q.size() == 0) begin
				$display("%0t: unexpected result %0d/%0d dz=%0b",
					$time, result_num, result_den, div_zero);
				errors++;
			end else begin
				got_sum = sum_q.pop_front();
				if (result_num !== got_sum.num) begin
					$display("%0t: result_num expected %0d actual %0d",
						$time, got_sum.num, result_num);
					errors++;
				end
				if (result_den !== got_sum.den) begin
					$display("%0t: result_den expected %0d actual %0d",
						$time, got_sum.den, result_den);
					errors++;
				end
				if (div_zero !== got_sum.dz) begin
					$display("%0t: div_zero expected %0b actual %0b",
						$time, got_sum.dz, div_zero);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cnt <= 0;
			else
				idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls, a stall-free stretch, and one long hold-off
	initial begin : receiver
		int cyc;
		int stall_left;
		cyc        = 0;
		stall_left = 0;
		out_ready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == HOLD_AT) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYC) @(negedge clk);
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if ((cyc < 60000 || cyc > 90000) && $urandom_range(0, 3) == 0)
					stall_left = idle_len();
			end
		end
	end

	// stimulus
	initial begin : stimulus
		fas_pkg::cmd_t c;
		opnd_t         an, ad, bn, bd;
		frac_t         e;
		errors   = 0;
		idle_cnt = 0;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		cmd      = 1'b0;
		a_num    = '0;
		a_den    = '0;
		b_num    = '0;
		b_den    = '0;
		pend_sum = '0;

		// directed rows: corners, both commands, zero denominators, zero numerators
		dir_rows = '{
			'{fas_pkg::CMD_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b1, '{33'sd5, 31'd6, 1'b0}},
			'{fas_pkg::CMD_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b1, '{33'sd1, 31'd6, 1'b0}},
			'{fas_pkg::CMD_ADD, 16'sd5, 16'sd0, 16'sd1, 16'sd3, 1'b1, '{33'sd0, 31'd1, 1'b1}},
			'{fas_pkg::CMD_SUB, 16'sd5, 16'sd7, 16'sd1, 16'sd0, 1'b1, '{33'sd0, 31'd1, 1'b1}},
			'{fas_pkg::CMD_ADD, SMIN,   16'sd0, SMAX,   16'sd0, 1'b1, '{33'sd0, 31'd1, 1'b1}},
			'{fas_pkg::CMD_SUB, 16'sd0, 16'sd0, 16'sd0, 16'sd9, 1'b1, '{33'sd0, 31'd1, 1'b1}},
			'{fas_pkg::CMD_ADD, 16'sd0, 16'sd5, 16'sd0, -16'sd7, 1'b1, '{33'sd0, 31'd1, 1'b0}},
			'{fas_pkg::CMD_SUB, 16'sd3, 16'sd4, 16'sd3, 16'sd4, 1'b1, '{33'sd0, 31'd1, 1'b0}},
			'{fas_pkg::CMD_SUB, -16'sd3, -16'sd4, 16'sd3, 16'sd4, 1'b1,
				'{33'sd0, 31'd1, 1'b0}},
			'{fas_pkg::CMD_ADD, SMIN,   16'sd1, SMIN,   16'sd1, 1'b1,
				'{-33'sd65536, 31'd1, 1'b0}},
			'{fas_pkg::CMD_SUB, SMIN,   16'sd1, SMIN,   16'sd1, 1'b1, '{33'sd0, 31'd1, 1'b0}},
			'{fas_pkg::CMD_ADD, SMAX,   16'sd1, SMAX,   16'sd1, 1'b1,
				'{33'sd65534, 31'd1, 1'b0}},
			'{fas_pkg::CMD_ADD, 16'sd1, -16'sd2, 16'sd0, 16'sd1, 1'b1,
				'{-33'sd1, 31'd2, 1'b0}},
			'{fas_pkg::CMD_SUB, 16'sd7, 16'sd1, 16'sd9, 16'sd1, 1'b1, '{-33'sd2, 31'd1, 1'b0}},
			'{fas_pkg::CMD_ADD, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b1,
				'{33'sd2, 31'd1, 1'b0}},
			'{fas_pkg::CMD_ADD, SMIN,   SMIN,   SMIN,   SMIN,   1'b1, '{33'sd2, 31'd1, 1'b0}},
			'{fas_pkg::CMD_SUB, SMIN,   SMAX,   SMAX,   SMIN,   1'b0, '0},
			'{fas_pkg::CMD_ADD, SMAX,   SMIN,   SMAX,   SMIN + 16'sd1, 1'b0, '0},
			'{fas_pkg::CMD_ADD, 16'sd1, SMIN,   16'sd1, SMAX,   1'b0, '0},
			'{fas_pkg::CMD_SUB, SMAX,   16'sd32766, SMIN, 16'sd32765, 1'b0, '0}
		};

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			e = dir_rows[i].typed ? dir_rows[i].e :
				reduce_sum(dir_rows[i].c, dir_rows[i].an, dir_rows[i].ad,
					dir_rows[i].bn, dir_rows[i].bd);
			send_item(dir_rows[i].c, dir_rows[i].an, dir_rows[i].ad,
				dir_rows[i].bn, dir_rows[i].bd, e);
			idle_sender(idle_len());
		end

		// random part: mostly mixed operands, some forced zero cases
		for (int k = 0; k < RAND_ITEMS; k++) begin
			c  = fas_pkg::cmd_t'($urandom_range(0, 1));
			an = rand_opnd();
			ad = rand_opnd();
			bn = rand_opnd();
			bd = rand_opnd();
			case ($urandom_range(0, 19))
				0: ad = '0;
				1: bd = '0;
				2: begin
					bn = an;
					bd = ad;
					c  = fas_pkg::CMD_SUB;
				end
				3: begin
					an = '0;
					bn = '0;
				end
				4: begin
					bn = -an;
					bd = ad;
					c  = fas_pkg::CMD_ADD;
				end
				default: ;
			endcase
			send_item(c, an, ad, bn, bd, reduce_sum(c, an, ad, bn, bd));
			if (k == PAUSE_AT) begin
				// hold the input until the block has drained completely
				in_valid <= 1'b0;
				while (sum_q.size() != 0)
					@(negedge clk);
			end else if (k < 400 || k >= 520) begin
				idle_sender(idle_len());
			end
		end
		in_valid <= 1'b0;

		while (sum_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (errors == 0 && sum_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/fas_pkg.sv
rtl/fas_reduce.sv
rtl/fraction_add_sub_reduce_core.sv
tb/testbench.sv
